// ===== rtl/core/multi_pattern_byte_matcher_assert.svh =====
// assertion macros for the multi-pattern byte matcher
// no dependencies; checks drop out when SYNTH is defined
`ifndef MULTI_PATTERN_BYTE_MATCHER_ASSERT_SVH
`define MULTI_PATTERN_BYTE_MATCHER_ASSERT_SVH

`ifndef SYNTH
// implication checked on every rising clock edge outside reset
`define MPBM_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("mpbm assertion failed");
// condition that must never hold outside reset
`define MPBM_ASSERT_NEVER(label, cond) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("mpbm forbidden condition");
`else
`define MPBM_ASSERT(label, prop)
`define MPBM_ASSERT_NEVER(label, cond)
`endif

`endif

// ===== rtl/core/mpbm_pkg.sv =====
// shared types and constants of the multi-pattern byte matcher
// no dependencies
package mpbm_pkg;

  localparam int unsigned NUM_PATTERNS      = 4;
  localparam int unsigned MAX_PATTERN_BYTES = 8;
  localparam int unsigned BYTE_W            = 8;
  localparam int unsigned WORD_W            = MAX_PATTERN_BYTES * BYTE_W;
  localparam int unsigned HIST_W            = WORD_W - BYTE_W;
  localparam int unsigned LEN_W             = 4;
  localparam int unsigned SEEN_W            = 3;
  localparam int unsigned CFG_IDX_W         = 4;
  localparam int unsigned CFG_DATA_W        = 64;
  localparam int unsigned OUT_TDATA_W       = 8;

  // register map
  localparam logic [CFG_IDX_W-1:0] REG_WORD_BASE = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LEN_BASE  = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_END       = 4'd8;

  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic [LEN_W-1:0]  len;
  } pattern_t;

  typedef pattern_t [NUM_PATTERNS-1:0] pattern_arr_t;

  // one byte moving from the input register into the window
  typedef struct packed {
    logic valid;
    logic last;
  } step_t;

endpackage

// ===== rtl/core/mpbm_cfg_regs.sv =====
// pattern configuration registers of the multi-pattern byte matcher
// depends on mpbm_pkg
module mpbm_cfg_regs (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_valid_i,
  input  logic [mpbm_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [mpbm_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  output mpbm_pkg::pattern_arr_t               patterns_o
);

  mpbm_pkg::pattern_arr_t pat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_q <= '0;
    end else if (cfg_valid_i) begin
      for (int p = 0; p < mpbm_pkg::NUM_PATTERNS; p++) begin
        if (cfg_index_i == mpbm_pkg::REG_WORD_BASE + mpbm_pkg::CFG_IDX_W'(p)) begin
          pat_q[p].word <= cfg_data_i[mpbm_pkg::WORD_W-1:0];
        end
        if (cfg_index_i == mpbm_pkg::REG_LEN_BASE + mpbm_pkg::CFG_IDX_W'(p)) begin
          pat_q[p].len <= cfg_data_i[mpbm_pkg::LEN_W-1:0];
        end
      end
    end
  end

  assign patterns_o = pat_q;

endmodule

// ===== rtl/core/mpbm_window.sv =====
// byte history window and parallel pattern compare
// depends on mpbm_pkg and multi_pattern_byte_matcher_assert.svh
`include "multi_pattern_byte_matcher_assert.svh"

module mpbm_window (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  mpbm_pkg::step_t                  step_i,
  input  logic [mpbm_pkg::BYTE_W-1:0]      byte_i,
  input  mpbm_pkg::pattern_arr_t           patterns_i,
  output logic                             hit_o
);

  logic [mpbm_pkg::HIST_W-1:0] recent_q;
  logic [mpbm_pkg::SEEN_W-1:0] seen_q;
  logic                        hit_q;

  logic [mpbm_pkg::WORD_W-1:0] win;
  logic [mpbm_pkg::LEN_W-1:0]  avail;
  logic [mpbm_pkg::MAX_PATTERN_BYTES-1:0] len_match [mpbm_pkg::NUM_PATTERNS];
  logic [mpbm_pkg::NUM_PATTERNS-1:0]      pat_hit;
  logic [mpbm_pkg::SEEN_W-1:0]            len_sel [mpbm_pkg::NUM_PATTERNS];
  logic                                   hit_now;

  assign win   = {recent_q, byte_i};
  assign avail = {1'b0, seen_q} + mpbm_pkg::LEN_W'(1);

  // for every pattern and every possible length, match the pattern head
  // against the bytes that end at the newest one
  always_comb begin
    for (int p = 0; p < mpbm_pkg::NUM_PATTERNS; p++) begin
      for (int l = 0; l < mpbm_pkg::MAX_PATTERN_BYTES; l++) begin
        len_match[p][l] = 1'b1;
        for (int i = 0; i <= l; i++) begin
          if (patterns_i[p].word[mpbm_pkg::BYTE_W*i +: mpbm_pkg::BYTE_W] !=
              win[mpbm_pkg::BYTE_W*(l-i) +: mpbm_pkg::BYTE_W]) begin
            len_match[p][l] = 1'b0;
          end
        end
      end
      len_sel[p] = mpbm_pkg::SEEN_W'(patterns_i[p].len - mpbm_pkg::LEN_W'(1));
      pat_hit[p] = (patterns_i[p].len != '0) &&
                   (patterns_i[p].len <= mpbm_pkg::LEN_W'(mpbm_pkg::MAX_PATTERN_BYTES)) &&
                   (patterns_i[p].len <= avail) &&
                   len_match[p][len_sel[p]];
    end
  end

  assign hit_now = |pat_hit;
  assign hit_o   = hit_q | hit_now;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      recent_q <= '0;
      seen_q   <= '0;
      hit_q    <= 1'b0;
    end else if (step_i.valid) begin
      if (step_i.last) begin
        recent_q <= '0;
        seen_q   <= '0;
        hit_q    <= 1'b0;
      end else begin
        recent_q <= win[mpbm_pkg::HIST_W-1:0];
        if (seen_q != mpbm_pkg::SEEN_W'(mpbm_pkg::MAX_PATTERN_BYTES - 1)) begin
          seen_q <= seen_q + mpbm_pkg::SEEN_W'(1);
        end
        hit_q <= hit_o;
      end
    end
  end

  `MPBM_ASSERT(a_clear_after_last, (step_i.valid && step_i.last) |=> !(|{recent_q, seen_q, hit_q}))
  `MPBM_ASSERT_NEVER(a_hit_without_bytes, hit_q && seen_q == '0)

endmodule

// ===== rtl/core/multi_pattern_byte_matcher.sv =====
// a last byte waits for a free result slot; its verdict is registered on m_axis_tvalid
// throughput: one byte per cycle; only a held verdict can stall the last byte of a buffer
// window compare of all four patterns sits between the input and result registers
// reset: asynchronous active low; clears handshakes, window, history and all patterns
// configuration writes are always ready and take effect at the next edge
// depends on mpbm_pkg, mpbm_cfg_regs, mpbm_window, multi_pattern_byte_matcher_assert.svh
`include "multi_pattern_byte_matcher_assert.svh"

module multi_pattern_byte_matcher (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // byte stream in
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [mpbm_pkg::BYTE_W-1:0]          s_axis_tdata,   // [7:0] data_byte
  input  logic                                 s_axis_tlast,   // last_of_buffer
  // verdict out, one beat per buffer
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [mpbm_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,   // [0] found, [7:1] zero
  // configuration write channel
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [mpbm_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [mpbm_pkg::CFG_DATA_W-1:0]      cfg_data_i
);

  mpbm_pkg::pattern_arr_t patterns;
  mpbm_pkg::step_t        step;

  // input register
  logic                        in_valid_q;
  logic [mpbm_pkg::BYTE_W-1:0] in_byte_q;
  logic                        in_last_q;

  // result register
  logic out_valid_q;
  logic found_q;

  logic out_free;
  logic advance;
  logic in_take;
  logic hit;

  // a non-last byte always moves on; a last byte needs the result slot
  assign out_free      = !out_valid_q || m_axis_tready;
  assign advance       = in_valid_q && (!in_last_q || out_free);
  assign s_axis_tready = !in_valid_q || advance;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  assign step.valid = advance;
  assign step.last  = in_last_q;

  assign cfg_ready_o = 1'b1;

  mpbm_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .patterns_o  (patterns)
  );

  mpbm_window u_window (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (step),
    .byte_i     (in_byte_q),
    .patterns_i (patterns),
    .hit_o      (hit)
  );

  // input register: refilled in the same cycle the held byte moves on
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_byte_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
  end

  // result register: loaded on the last byte of a buffer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && in_last_q) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_last_q) begin
      found_q <= hit;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(mpbm_pkg::OUT_TDATA_W-1){1'b0}}, found_q};

  // a verdict only ever appears after a last byte left the input register
  `MPBM_ASSERT(a_verdict_from_last, $rose(out_valid_q) |-> $past(advance && in_last_q))
  // a stalled input byte is neither lost nor overwritten
  `MPBM_ASSERT(a_input_held, !s_axis_tready |=> $stable({in_valid_q, in_byte_q, in_last_q}))

endmodule

// ===== tb/tb_multi_pattern_byte_matcher.sv =====
// self-checking testbench for the multi-pattern byte matcher: a directed table, then random
// buffers over a dozen pattern settings and four idling phases, each checked by a local predictor
// depends on mpbm_pkg and the multi_pattern_byte_matcher rtl
module tb_multi_pattern_byte_matcher;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NUM_PATTERNS      = mpbm_pkg::NUM_PATTERNS;
  localparam int unsigned MAX_PATTERN_BYTES = mpbm_pkg::MAX_PATTERN_BYTES;
  localparam int unsigned BYTE_W            = mpbm_pkg::BYTE_W;
  localparam int unsigned WORD_W            = mpbm_pkg::WORD_W;
  localparam int unsigned HIST_W            = mpbm_pkg::HIST_W;
  localparam int unsigned LEN_W             = mpbm_pkg::LEN_W;
  localparam int unsigned SEEN_W            = mpbm_pkg::SEEN_W;
  localparam int unsigned CFG_IDX_W         = mpbm_pkg::CFG_IDX_W;
  localparam int unsigned CFG_DATA_W        = mpbm_pkg::CFG_DATA_W;
  localparam int unsigned OUT_TDATA_W       = mpbm_pkg::OUT_TDATA_W;
  localparam logic [CFG_IDX_W-1:0] REG_WORD_BASE = mpbm_pkg::REG_WORD_BASE;
  localparam logic [CFG_IDX_W-1:0] REG_LEN_BASE  = mpbm_pkg::REG_LEN_BASE;
  localparam logic [CFG_IDX_W-1:0] REG_END       = mpbm_pkg::REG_END;

  localparam int unsigned CYCLE_LIMIT        = 200000;
  // spare cycles after the last verdict so the pipe has drained
  localparam int unsigned DRAIN_CYCLES       = 4;
  localparam int unsigned BYTES_PER_SETTING  = 100;
  localparam int unsigned SETTINGS_PER_PHASE = 3;
  localparam int unsigned NUM_PHASES         = 4;

  typedef enum logic {
    ROW_BYTE,
    ROW_REG
  } row_kind_e;

  // one row of the directed table: either a register write or a stream beat
  typedef struct {
    row_kind_e              kind;
    logic [CFG_IDX_W-1:0]   idx;
    logic [CFG_DATA_W-1:0]  val;
    logic [BYTE_W-1:0]      data;
    logic                   last;
    bit                     typed;        // verdict typed in below rather than predicted
    logic                   typed_found;
  } dir_row_t;

  // dut connections, every input known from time zero
  logic                   clk_i;
  logic                   rst_ni        = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [BYTE_W-1:0]      s_axis_tdata  = '0;   // [7:0] data_byte
  logic                   s_axis_tlast  = 1'b0; // last_of_buffer
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;         // [0] found, [7:1] zero
  logic                   cfg_valid_i   = 1'b0;
  logic                   cfg_ready_o;
  logic [CFG_IDX_W-1:0]   cfg_index_i   = '0;
  logic [CFG_DATA_W-1:0]  cfg_data_i    = '0;

  // predictor state: pattern registers plus the byte window of the current buffer
  logic [WORD_W-1:0] pat_word_m [NUM_PATTERNS];
  logic [LEN_W-1:0]  pat_len_m  [NUM_PATTERNS];
  logic [HIST_W-1:0] hist_m;
  logic [SEEN_W-1:0] seen_m;
  logic              hit_m;

  // verdicts still owed by the dut, oldest first
  logic              verdict_q [$];
  dir_row_t          dir_rows  [$];
  logic [BYTE_W-1:0] alpha_m   [4];  // byte alphabet of the current setting

  int unsigned src_idle_pct  = 0;
  int unsigned snk_stall_pct = 0;
  int unsigned n_errors      = 0;
  int unsigned n_bytes       = 0;
  int unsigned n_buffers     = 0;
  int unsigned n_found       = 0;
  int unsigned n_settings    = 0;
  int unsigned n_checked     = 0;
  int unsigned cycles        = 0;

  multi_pattern_byte_matcher u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------------------------

  // does the pattern end exactly at the newest byte of the window
  function automatic logic pattern_ends_here(input logic [WORD_W-1:0] win,
                                             input int unsigned avail,
                                             input logic [WORD_W-1:0] word,
                                             input logic [LEN_W-1:0] len);
    int unsigned n;
    n = 32'(len);
    // zero disables, lengths above the window never match, nor do ones longer than seen so far
    if (n == 0 || n > MAX_PATTERN_BYTES || n > avail) return 1'b0;
    for (int unsigned i = 0; i < n; i++) begin
      if (word[BYTE_W*i +: BYTE_W] != win[BYTE_W*(n-1-i) +: BYTE_W]) return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic predict_byte(input logic [BYTE_W-1:0] data, input logic last,
                              output logic verdict);
    logic [WORD_W-1:0] win;
    logic              hit;
    win = {hist_m, data};
    hit = hit_m;
    for (int p = 0; p < NUM_PATTERNS; p++) begin
      if (pattern_ends_here(win, int'(seen_m) + 1, pat_word_m[p], pat_len_m[p])) hit = 1'b1;
    end
    verdict = hit;
    n_bytes++;
    if (last) begin
      // buffer closed: no pattern may carry into the next one
      hist_m = '0;
      seen_m = '0;
      hit_m  = 1'b0;
    end else begin
      hist_m = win[HIST_W-1:0];
      if (seen_m < SEEN_W'(MAX_PATTERN_BYTES - 1)) seen_m++;
      hit_m = hit;
    end
  endtask

  task automatic apply_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    if (idx < REG_LEN_BASE) begin
      pat_word_m[idx - REG_WORD_BASE] = val;
    end else if (idx < REG_END) begin
      pat_len_m[idx - REG_LEN_BASE] = val[LEN_W-1:0];
    end
    // indexes past the map are dropped
  endtask

  // ---------------------------------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------------------------------

  // valid stays high across a burst of writes; the next stream beat lowers it
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    apply_reg(idx, val);
  endtask

  task automatic send_byte(input logic [BYTE_W-1:0] data, input logic last,
                           input bit typed, input logic typed_found);
    logic verdict;
    if (cfg_valid_i) cfg_valid_i <= 1'b0;
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= data;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_byte(data, last, verdict);
    if (last) begin
      if (typed) verdict = typed_found;
      verdict_q.insert(verdict_q.size(), verdict);
      n_buffers++;
      if (verdict) n_found++;
    end
  endtask

  // sender holds off until every owed verdict is out and the pipe is empty
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic add_byte(input logic [BYTE_W-1:0] data, input logic last,
                          input bit typed = 1'b0, input logic typed_found = 1'b0);
    dir_row_t r;
    r = '{ROW_BYTE, '0, '0, data, last, typed, typed_found};
    dir_rows.insert(dir_rows.size(), r);
  endtask

  task automatic add_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    dir_row_t r;
    r = '{ROW_REG, idx, val, '0, 1'b0, 1'b0, 1'b0};
    dir_rows.insert(dir_rows.size(), r);
  endtask

  // new random pattern set; the first settings of each phase go to the length extremes
  task automatic load_random_setting(input int unsigned k);
    logic [WORD_W-1:0]     word;
    logic [CFG_DATA_W-1:0] lv;
    int unsigned           len;
    int unsigned           r;
    wait_idle();
    alpha_m[0] = 8'h00;
    alpha_m[1] = BYTE_W'($urandom_range(0, 255));
    alpha_m[2] = BYTE_W'($urandom_range(0, 255));
    alpha_m[3] = 8'hff;
    if ($urandom_range(0, 1)) begin
      write_reg(REG_END + CFG_IDX_W'($urandom_range(0, 7)), {$urandom, $urandom});
    end
    for (int p = 0; p < NUM_PATTERNS; p++) begin
      r = $urandom_range(0, 19);
      if (k % SETTINGS_PER_PHASE == 0)      len = MAX_PATTERN_BYTES;
      else if (k % SETTINGS_PER_PHASE == 1 && p < 2) len = 1;
      else if (r < 2)                       len = 0;
      else if (r < 4)                       len = $urandom_range(MAX_PATTERN_BYTES + 1, 15);
      else if (r < 7)                       len = MAX_PATTERN_BYTES;
      else if (r < 9)                       len = 1;
      else                                  len = $urandom_range(2, MAX_PATTERN_BYTES - 1);
      if ($urandom_range(0, 1)) begin
        word = {$urandom, $urandom};
      end else begin
        for (int b = 0; b < MAX_PATTERN_BYTES; b++) begin
          word[BYTE_W*b +: BYTE_W] = alpha_m[$urandom_range(0, 3)];
        end
      end
      // length registers only keep their low bits, so junk above them now and then
      lv = $urandom_range(0, 1) ? {$urandom, $urandom} : '0;
      lv[LEN_W-1:0] = LEN_W'(len);
      write_reg(REG_WORD_BASE + CFG_IDX_W'(p), word);
      write_reg(REG_LEN_BASE + CFG_IDX_W'(p), lv);
    end
    n_settings++;
  endtask

  // buffer of random content, mostly built from whole or partial copies of the live patterns
  task automatic send_buffer();
    logic [BYTE_W-1:0] bytes_q [$];
    int unsigned       blen;
    int unsigned       p;
    int unsigned       n;
    int unsigned       r;
    blen = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
    while (bytes_q.size() < blen) begin
      r = $urandom_range(0, 9);
      if (r < 5) begin
        p = $urandom_range(0, NUM_PATTERNS - 1);
        n = 32'(pat_len_m[p]);
        if (n == 0 || n > MAX_PATTERN_BYTES) n = MAX_PATTERN_BYTES;
        if ($urandom_range(0, 3) == 0) n = $urandom_range(1, n);
        for (int unsigned i = 0; i < n; i++) begin
          bytes_q.insert(bytes_q.size(), pat_word_m[p][BYTE_W*i +: BYTE_W]);
        end
      end else if (r < 8) begin
        bytes_q.insert(bytes_q.size(), alpha_m[$urandom_range(0, 3)]);
      end else begin
        bytes_q.insert(bytes_q.size(), BYTE_W'($urandom_range(0, 255)));
      end
    end
    foreach (bytes_q[i]) send_byte(bytes_q[i], i == bytes_q.size() - 1, 1'b0, 1'b0);
  endtask

  // ---------------------------------------------------------------------------------------------
  // verdict monitor: checks every accepted beat and stalls at random
  // ---------------------------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    logic                   exp;
    logic [OUT_TDATA_W-1:0] want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (verdict_q.size() == 0) begin
          $display("%0t: verdict beat %h with nothing expected", $time, m_axis_tdata);
          n_errors++;
        end else begin
          exp  = verdict_q.pop_front();
          // found sits in bit 0, the padding above it must read zero
          want = {{(OUT_TDATA_W-1){1'b0}}, exp};
          n_checked++;
          if (m_axis_tdata !== want) begin
            $display("%0t: verdict mismatch, expected %h, got %h", $time, want, m_axis_tdata);
            n_errors++;
          end
        end
      end
      m_axis_tready <= ($urandom_range(0, 99) >= snk_stall_pct);
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d verdicts still owed", cycles, verdict_q.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------------------------
  initial begin
    for (int p = 0; p < NUM_PATTERNS; p++) begin
      pat_word_m[p] = '0;
      pat_len_m[p]  = '0;
    end
    hist_m = '0;
    seen_m = '0;
    hit_m  = 1'b0;

    // after reset every length is zero, so nothing can match
    add_byte(8'h00, 1'b0);
    add_byte(8'hff, 1'b0);
    add_byte(8'h80, 1'b1, 1'b1, 1'b0);
    add_byte(8'h01, 1'b1, 1'b1, 1'b0);
    // two-byte pattern, a full eight-byte one, a one-byte one with junk above it,
    // and one whose length is past the window so it stays dead
    add_reg(REG_WORD_BASE + 4'd0, 64'h0000_0000_0000_4241);
    add_reg(REG_LEN_BASE  + 4'd0, 64'd2);
    add_reg(REG_WORD_BASE + 4'd1, 64'h8877_6655_4433_2211);
    add_reg(REG_LEN_BASE  + 4'd1, 64'd8);
    add_reg(REG_WORD_BASE + 4'd2, 64'hffff_ffff_ffff_ffff);
    add_reg(REG_LEN_BASE  + 4'd2, 64'd1);
    add_reg(REG_WORD_BASE + 4'd3, 64'h0);
    add_reg(REG_LEN_BASE  + 4'd3, 64'hffff_ffff_ffff_fff0 | 64'd15);
    add_reg(REG_END + 4'd7, 64'hffff_ffff_ffff_ffff);  // beyond the map, dropped
    add_byte(8'h41, 1'b0);
    add_byte(8'h42, 1'b1);
    add_byte(8'h42, 1'b0);
    add_byte(8'h41, 1'b1);
    // split across two buffers must not match
    add_byte(8'h41, 1'b1);
    add_byte(8'h42, 1'b1);
    add_byte(8'hff, 1'b1);
    add_byte(8'h00, 1'b0);
    add_byte(8'h00, 1'b0);
    add_byte(8'h00, 1'b1);
    // eight-byte pattern behind a leading byte fills the whole window
    add_byte(8'h01, 1'b0);
    for (int i = 1; i <= 8; i++) add_byte(BYTE_W'(8'h11 * i), i == 8);

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_REG) begin
        if (!cfg_valid_i) wait_idle();
        write_reg(dir_rows[i].idx, dir_rows[i].val);
      end else begin
        send_byte(dir_rows[i].data, dir_rows[i].last, dir_rows[i].typed,
                  dir_rows[i].typed_found);
      end
    end

    // idling phases: none, sender mostly idle, receiver mostly stalled, both now and then;
    // each new setting starts with the sender holding off until the pipe has drained
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: begin
          src_idle_pct  = 0;
          snk_stall_pct = 0;
        end
        1: begin
          src_idle_pct  = 86;
          snk_stall_pct = 0;
        end
        2: begin
          src_idle_pct  = 0;
          snk_stall_pct = 86;
        end
        default: begin
          src_idle_pct  = 29;
          snk_stall_pct = 29;
        end
      endcase
      for (int s = 0; s < SETTINGS_PER_PHASE; s++) begin
        int unsigned start_bytes;
        load_random_setting(s);
        start_bytes = n_bytes;
        while (n_bytes - start_bytes < BYTES_PER_SETTING) send_buffer();
      end
    end

    wait_idle();
    $display("%0d bytes in %0d buffers, %0d verdicts checked, %0d of them a match",
             n_bytes, n_buffers, n_checked, n_found);
    $display("%0d random pattern settings over %0d idling phases, %0d errors",
             n_settings, NUM_PHASES, n_errors);
    if (n_errors == 0 && verdict_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/mpbm_pkg.sv
rtl/core/mpbm_cfg_regs.sv
rtl/core/mpbm_window.sv
rtl/core/multi_pattern_byte_matcher.sv
tb/tb_multi_pattern_byte_matcher.sv
